>>> rtl/pcc_pkg.sv
// Package: shared types, constants and helpers of the 12-bit coefficient codec.
`timescale 1ns / 1ps
package pcc_pkg;

  localparam int unsigned MAX_COEFFS_DEFAULT = 2048;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [11:0] MODULUS_RESET = 12'd3457;
  localparam logic [11:0] COUNT_RESET   = 12'd768;

  localparam int unsigned FREEZE_MUL_SHIFT = 3;        // x*9 = (x << 3) + x
  localparam logic [19:0] FREEZE_ROUND     = 20'd16384;
  localparam logic [11:0] EVEN_MASK        = 12'hffe;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_COUNT = 2'd1;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } back_state_e;

  // Queue entry: operation, raw payload and freeze quotient estimate.
  typedef struct packed {
    logic               op;
    logic [15:0]        data;
    logic signed [4:0]  quot;
  } entry_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [11:0] coeff_out;
    logic        last;
    logic        poly_done;
    logic        range_error;
  } result_t;

  // Effective polynomial length: even, clamped to 2 .. max_coeffs.
  function automatic logic [12:0] poly_len(logic [11:0] count, int unsigned max_coeffs);
    logic [12:0] n;
    logic [12:0] m;
    n = {1'b0, count & EVEN_MASK};
    m = 13'(max_coeffs) & ~13'd1;
    if (n < 13'd2) begin
      n = 13'd2;
    end
    if (n > 13'(max_coeffs)) begin
      n = m;
    end
    return n;
  endfunction

endpackage

>>> rtl/pcc_if.sv
// Interfaces: input, result and configuration channels of the codec.
`timescale 1ns / 1ps
interface pcc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] coeff_in;
  logic [7:0]  wire_byte;

  modport source (output valid, output operation, output coeff_in, output wire_byte,
                  input ready);
  modport sink (input valid, input operation, input coeff_in, input wire_byte,
                output ready);
endinterface

interface pcc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [11:0] coeff_out;
  logic        last;
  logic        poly_done;
  logic        range_error;

  modport source (output valid, output byte_out, output coeff_out, output last,
                  output poly_done, output range_error, input ready);
  modport sink (input valid, input byte_out, input coeff_out, input last,
                input poly_done, input range_error, output ready);
endinterface

interface pcc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pcc_pkg::CFG_IDX_W-1:0]   index;
  logic [11:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/pcc_front.sv
// Front stage: takes input transfers, classifies them and estimates the freeze quotient.
`timescale 1ns / 1ps
module pcc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [15:0]      coeff_in_i,
  input  logic [7:0]       wire_byte_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output pcc_pkg::entry_t  push_entry_o
);

  logic            vld_q, vld_d;
  pcc_pkg::entry_t ent_q, ent_d;
  logic signed [19:0] x_ext;
  logic signed [19:0] rnd_sum;
  logic               take;

  assign in_ready_o = !vld_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // t = (9x + 2^14) >>> 15, range -9 .. 9
  always_comb begin
    x_ext   = 20'(signed'(coeff_in_i));
    rnd_sum = (x_ext <<< pcc_pkg::FREEZE_MUL_SHIFT) + x_ext
              + signed'(pcc_pkg::FREEZE_ROUND);
    ent_d   = ent_q;
    vld_d   = vld_q;
    if (push_ready_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d       = 1'b1;
      ent_d.op    = operation_i;
      ent_d.quot  = rnd_sum[19:15];
      ent_d.data  = (operation_i == pcc_pkg::OP_DECODE) ? {8'd0, wire_byte_i} : coeff_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign push_valid_o = vld_q;
  assign push_entry_o = ent_q;

endmodule

>>> rtl/pcc_queue.sv
// Queue: short FIFO between front and back stages.
`timescale 1ns / 1ps
module pcc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  pcc_pkg::entry_t  push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output pcc_pkg::entry_t  pop_entry_o
);

  localparam int unsigned Depth = pcc_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pcc_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> rtl/pcc_back.sv
// Back stage: freeze, pack/unpack, polynomial position and range flag; emits results.
`timescale 1ns / 1ps
module pcc_back #(
  parameter int unsigned MAX_COEFFS = pcc_pkg::MAX_COEFFS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [11:0]                   modulus_i,
  input  logic [$clog2(MAX_COEFFS+1)-1:0] len_i,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  pcc_pkg::entry_t               pop_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pcc_pkg::result_t              out_res_o
);

  localparam int unsigned PW = $clog2(MAX_COEFFS);
  localparam int unsigned LW = $clog2(MAX_COEFFS + 1);

  pcc_pkg::back_state_e state_q, state_d;
  logic [15:0]   pend_q, pend_d;
  logic [1:0]    phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          sticky_q, sticky_d;
  logic          op_q, op_d;
  logic [15:0]   data_q, data_d;
  logic [15:0]   prod_q, prod_d;
  pcc_pkg::result_t res_q [3];
  pcc_pkg::result_t res_d [3];
  logic [1:0]    cnt_q, cnt_d, idx_q, idx_d;

  logic signed [17:0] prod_full;
  logic [15:0]   fr_r, fr_s;
  logic [11:0]   frozen, c0, dc;
  logic [LW:0]   pos_ext, len_ext;
  logic          enc_done, dec_end, dec_bad;

  assign prod_full = $signed(pop_entry_i.quot) * $signed({1'b0, modulus_i});
  assign pop_ready_o = (state_q == pcc_pkg::ST_IDLE);
  assign out_valid_o = (state_q == pcc_pkg::ST_EMIT);
  assign out_res_o   = res_q[idx_q];

  always_comb begin
    fr_r    = data_q - prod_q;
    fr_s    = fr_r + {4'd0, modulus_i};
    frozen  = (fr_r < fr_s) ? fr_r[11:0] : fr_s[11:0];
    c0      = pend_q[11:0];
    pos_ext = {{(LW + 1 - PW){1'b0}}, pos_q};
    len_ext = {1'b0, len_i};
    enc_done = (pos_ext + (LW+1)'(2) >= len_ext);
    dec_end  = (pos_ext + (LW+1)'(1) >= len_ext);
    if (phase_q == pcc_pkg::PH_ONE) begin
      dc = {data_q[3:0], pend_q[7:0]};
    end else begin
      dc = {data_q[7:0], pend_q[3:0]};
    end
    dec_bad = (dc >= modulus_i);
  end

  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    phase_d  = phase_q;
    pos_d    = pos_q;
    sticky_d = sticky_q;
    op_d     = op_q;
    data_d   = data_q;
    prod_d   = prod_q;
    res_d    = res_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    case (state_q)
      pcc_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          op_d    = pop_entry_i.op;
          data_d  = pop_entry_i.data;
          prod_d  = prod_full[15:0];
          state_d = pcc_pkg::ST_EXEC;
        end
      end
      pcc_pkg::ST_EXEC: begin
        idx_d   = 2'd0;
        state_d = pcc_pkg::ST_IDLE;
        for (int k = 0; k < 3; k++) begin
          res_d[k] = '0;
        end
        if (op_q == pcc_pkg::OP_ENCODE) begin
          if (phase_q == pcc_pkg::PH_EMPTY) begin
            pend_d  = {4'd0, frozen};
            phase_d = pcc_pkg::PH_ONE;
          end else begin
            res_d[0].byte_out  = c0[7:0];
            res_d[1].byte_out  = {frozen[3:0], c0[11:8]};
            res_d[2].byte_out  = frozen[11:4];
            res_d[2].last      = 1'b1;
            res_d[2].poly_done = enc_done;
            pos_d   = enc_done ? '0 : PW'(pos_ext + (LW+1)'(2));
            pend_d  = '0;
            phase_d = pcc_pkg::PH_EMPTY;
            cnt_d   = 2'd3;
            state_d = pcc_pkg::ST_EMIT;
          end
        end else begin
          if (phase_q == pcc_pkg::PH_EMPTY) begin
            pend_d  = data_q;
            phase_d = pcc_pkg::PH_ONE;
          end else begin
            if (phase_q == pcc_pkg::PH_ONE) begin
              pend_d  = {12'd0, data_q[7:4]};
              phase_d = pcc_pkg::PH_TWO;
            end else begin
              pend_d  = '0;
              phase_d = pcc_pkg::PH_EMPTY;
            end
            res_d[0].coeff_out = dc;
            res_d[0].last      = 1'b1;
            if (dec_end) begin
              res_d[0].poly_done   = 1'b1;
              res_d[0].range_error = sticky_q | dec_bad;
              sticky_d = 1'b0;
              pos_d    = '0;
            end else begin
              sticky_d = sticky_q | dec_bad;
              pos_d    = PW'(pos_ext + (LW+1)'(1));
            end
            cnt_d   = 2'd1;
            state_d = pcc_pkg::ST_EMIT;
          end
        end
      end
      pcc_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          if (idx_q == cnt_q - 2'd1) begin
            idx_d   = 2'd0;
            state_d = pcc_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = pcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcc_pkg::ST_IDLE;
      pend_q   <= '0;
      phase_q  <= pcc_pkg::PH_EMPTY;
      pos_q    <= '0;
      sticky_q <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      sticky_q <= sticky_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    data_q <= data_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  // result index stays inside the loaded burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < cnt_q))
    else $error("pcc_back: result index beyond burst");

  // execute lasts exactly one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcc_pkg::ST_EXEC) |=> (state_q != pcc_pkg::ST_EXEC))
    else $error("pcc_back: execute state held");

  // second coefficient of a pair closes the group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcc_pkg::ST_EXEC && op_q == pcc_pkg::OP_ENCODE
     && phase_q != pcc_pkg::PH_EMPTY) |=> (phase_q == pcc_pkg::PH_EMPTY && cnt_q == 2'd3))
    else $error("pcc_back: encode pair did not close");

  // no pop while a burst is still being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !pop_ready_o)
    else $error("pcc_back: pop during result burst");

endmodule

>>> rtl/poly_coeff_12bit_codec.sv
// Top level: 12-bit polynomial coefficient pack/unpack codec.
//
//   channel  dir  payload                                            handshake
//   in_i     in   operation, coeff_in, wire_byte                     valid/ready
//   out_o    out  byte_out, coeff_out, last, poly_done, range_error  valid/ready
//   cfg_i    in   index (0 modulus, 1 coeff_count), data             valid/ready (ready high)
//
// Front register and two-entry queue take a new transfer each cycle while room is left.
// The back stage pops an item, executes it, then sends that item's results, if any:
// a closing encode gives three bytes, an emitting decode byte gives one coefficient.
// It takes no new item until all results of the last one have been sent.
// Reset clears pipeline and codec state; configuration returns to modulus 3457, count 768.
// A stalled result port holds the back stage; front and queue keep filling meanwhile.
`timescale 1ns / 1ps
module poly_coeff_12bit_codec #(
  parameter int unsigned MAX_COEFFS = pcc_pkg::MAX_COEFFS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcc_in_if.sink        in_i,
  pcc_out_if.source     out_o,
  pcc_cfg_if.sink       cfg_i
);

  localparam int unsigned LW = $clog2(MAX_COEFFS + 1);

  logic [11:0]   modulus_q, modulus_d;
  logic [LW-1:0] len_q, len_d;
  logic [12:0]   len_full, len_rst;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  pcc_pkg::entry_t  push_entry, pop_entry;
  pcc_pkg::result_t res;

  assign cfg_i.ready = 1'b1;
  assign len_full    = pcc_pkg::poly_len(cfg_i.data, MAX_COEFFS);
  assign len_rst     = pcc_pkg::poly_len(pcc_pkg::COUNT_RESET, MAX_COEFFS);

  always_comb begin
    modulus_d = modulus_q;
    len_d     = len_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        pcc_pkg::CFG_MODULUS:     modulus_d = cfg_i.data;
        pcc_pkg::CFG_COEFF_COUNT: len_d     = len_full[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= pcc_pkg::MODULUS_RESET;
      len_q     <= len_rst[LW-1:0];
    end else begin
      modulus_q <= modulus_d;
      len_q     <= len_d;
    end
  end

  pcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .operation_i  (in_i.operation),
    .coeff_in_i   (in_i.coeff_in),
    .wire_byte_i  (in_i.wire_byte),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  pcc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  pcc_back #(
    .MAX_COEFFS (MAX_COEFFS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_i   (modulus_q),
    .len_i       (len_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.byte_out    = res.byte_out;
  assign out_o.coeff_out   = res.coeff_out;
  assign out_o.last        = res.last;
  assign out_o.poly_done   = res.poly_done;
  assign out_o.range_error = res.range_error;

endmodule
